/* rtl/aavr_pkg.sv */
// Shared types, constants and the arctangent table of the axis-angle rotation unit.
`timescale 1ns / 1ps

package aavr_pkg;

	// Defaults for the top-level parameters
	localparam int COORD_WIDTH_DEF  = 32;
	localparam int CORDIC_STEPS_DEF = 24;

	// Fixed internal sizes
	localparam int ATAN_LEN  = 40;   // entries in the arctangent table
	localparam int SQRT_BITS = 32;   // root bits of the 64-bit radicand
	localparam int QUOT_BITS = 31;   // quotient bits of the axis normalization

	// Q1.30 constants, and the half turn in binary angle units
	localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;

	// One word as it travels down the pipe
	typedef struct packed {
		logic [2:0][31:0] v;       // vector, sign extended to 32 bits
		logic [31:0]      angle;   // binary angle
		logic             zero;    // axis is all zero
		logic [2:0]       neg;     // axis component signs
	} item_t;

	// Sideband through the square root
	typedef struct packed {
		item_t            item;
		logic [2:0][31:0] mag;     // scaled axis magnitudes
	} norm_side_t;

	// Sideband through the CORDIC
	typedef struct packed {
		item_t            item;
		logic [2:0][31:0] u;       // unit axis, Q1.30
	} rot_side_t;

	// atan(2^-i) in binary angle units, 2^32 per turn
	function automatic logic [31:0] atan_entry(input int unsigned idx);
		logic [31:0] r;
		case (idx)
			0:  r = 32'd536870912;
			1:  r = 32'd316933406;
			2:  r = 32'd167458907;
			3:  r = 32'd85004756;
			4:  r = 32'd42667331;
			5:  r = 32'd21354465;
			6:  r = 32'd10679838;
			7:  r = 32'd5340245;
			8:  r = 32'd2670163;
			9:  r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			24: r = 32'd41;
			25: r = 32'd20;
			26: r = 32'd10;
			27: r = 32'd5;
			28: r = 32'd3;
			29: r = 32'd1;
			30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/aavr_norm.sv */
// Input stages: sign extension, axis magnitude scaling and sum of squares.
`timescale 1ns / 1ps

module aavr_norm
	import aavr_pkg::*;
#(
	parameter int IN_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_i,
	input  logic [31:0]      vec_x,
	input  logic [31:0]      vec_y,
	input  logic [31:0]      vec_z,
	input  logic [31:0]      axis_x,
	input  logic [31:0]      axis_y,
	input  logic [31:0]      axis_z,
	input  logic [31:0]      angle,
	output logic             valid_o,
	output norm_side_t       side_o,
	output logic [63:0]      m2_o
);

	localparam int EXT = 32 - IN_BITS;

	function automatic logic [31:0] sext_in(input logic [31:0] x);
		return 32'(($signed(x) <<< EXT) >>> EXT);
	endfunction

	logic             valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	item_t            item_s1, item_s2, item_s3, item_s4, item_s5;
	logic [2:0][31:0] mag_s1, mag_s2, mag_s3, mag_s4, mag_s5;
	logic [4:0]       sh_s2;
	logic [2:0][63:0] sq_s4;
	logic [63:0]      m2_s5;

	// Stage 1: sign extension and magnitudes
	logic [2:0][31:0] ax;
	logic [2:0][31:0] mag_c;
	item_t            item_c;
	always_comb begin
		ax[0] = sext_in(axis_x);
		ax[1] = sext_in(axis_y);
		ax[2] = sext_in(axis_z);
		for (int k = 0; k < 3; k++) begin
			mag_c[k] = ax[k][31] ? (~ax[k] + 32'd1) : ax[k];
		end
		item_c.v[0]  = sext_in(vec_x);
		item_c.v[1]  = sext_in(vec_y);
		item_c.v[2]  = sext_in(vec_z);
		item_c.angle = angle;
		item_c.zero  = (ax[0] == 32'd0) && (ax[1] == 32'd0) && (ax[2] == 32'd0);
		item_c.neg   = {ax[2][31], ax[1][31], ax[0][31]};
	end

	// Stage 2: largest magnitude and the shift that lifts it to [2^30, 2^31]
	logic [31:0] mx;
	logic [4:0]  msb;
	logic [4:0]  sh_c;
	always_comb begin
		mx = mag_s1[0];
		if (mag_s1[1] > mx) mx = mag_s1[1];
		if (mag_s1[2] > mx) mx = mag_s1[2];
		msb = 5'd0;
		for (int i = 0; i < 31; i++) begin
			if (mx[i]) msb = 5'(i);
		end
		sh_c = (mx[31] | mx[30]) ? 5'd0 : (5'd30 - msb);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Data path: scale, square, sum
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_c;
			mag_s1  <= mag_c;
			item_s2 <= item_s1;
			mag_s2  <= mag_s1;
			sh_s2   <= sh_c;
			item_s3 <= item_s2;
			for (int k = 0; k < 3; k++) begin
				mag_s3[k] <= mag_s2[k] << sh_s2;
				sq_s4[k]  <= 64'(mag_s3[k]) * 64'(mag_s3[k]);
			end
			item_s4 <= item_s3;
			mag_s4  <= mag_s3;
			item_s5 <= item_s4;
			mag_s5  <= mag_s4;
			m2_s5   <= sq_s4[0] + sq_s4[1] + sq_s4[2];
		end
	end

	assign valid_o     = valid_s5;
	assign side_o.item = item_s5;
	assign side_o.mag  = mag_s5;
	assign m2_o        = m2_s5;

endmodule

/* rtl/aavr_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module aavr_sqrt
	import aavr_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_i,
	input  logic [63:0]       rad_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              valid_o,
	output logic [31:0]       root_o,
	output logic [SIDE_W-1:0] side_o
);

	logic              valid_s [SQRT_BITS];
	logic [33:0]       rem_s   [SQRT_BITS];
	logic [31:0]       root_s  [SQRT_BITS];
	logic [63:0]       rad_s   [SQRT_BITS];
	logic [SIDE_W-1:0] side_s  [SQRT_BITS];

	for (genvar j = 0; j < SQRT_BITS; j++) begin : g_stage
		logic              pv;
		logic [33:0]       prem;
		logic [31:0]       proot;
		logic [63:0]       prad;
		logic [SIDE_W-1:0] pside;
		logic [35:0]       cur, trial;
		logic [33:0]       rem_n;
		logic [31:0]       root_n;

		if (j == 0) begin : g_first
			assign pv    = valid_i;
			assign prem  = '0;
			assign proot = '0;
			assign prad  = rad_i;
			assign pside = side_i;
		end else begin : g_next
			assign pv    = valid_s[j-1];
			assign prem  = rem_s[j-1];
			assign proot = root_s[j-1];
			assign prad  = rad_s[j-1];
			assign pside = side_s[j-1];
		end

		// Bring down two radicand bits, try root*4+1
		always_comb begin
			cur   = {prem, prad[63:62]};
			trial = {2'b00, proot, 2'b01};
			if (cur >= trial) begin
				rem_n  = 34'(cur - trial);
				root_n = {proot[30:0], 1'b1};
			end else begin
				rem_n  = cur[33:0];
				root_n = {proot[30:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (en) begin
				valid_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= rem_n;
				root_s[j] <= root_n;
				rad_s[j]  <= {prad[61:0], 2'b00};
				side_s[j] <= pside;
			end
		end
	end

	assign valid_o = valid_s[SQRT_BITS-1];
	assign root_o  = root_s[SQRT_BITS-1];
	assign side_o  = side_s[SQRT_BITS-1];

endmodule

/* rtl/aavr_div.sv */
// Pipelined rounded division of three axis magnitudes by the root, one bit per stage.
`timescale 1ns / 1ps

module aavr_div
	import aavr_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_i,
	input  logic [2:0][31:0]            mag_i,
	input  logic [31:0]                 root_i,
	input  logic [SIDE_W-1:0]           side_i,
	output logic                        valid_o,
	output logic [2:0][QUOT_BITS-1:0]   quot_o,
	output logic [SIDE_W-1:0]           side_o
);

	// Dividend with half the divisor added for rounding
	logic              valid_s0;
	logic [2:0][61:0]  num_s0;
	logic [31:0]       root_s0;
	logic [SIDE_W-1:0] side_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en) begin
			valid_s0 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				num_s0[k] <= {mag_i[k], 30'd0} + 62'(root_i >> 1);
			end
			root_s0 <= root_i;
			side_s0 <= side_i;
		end
	end

	logic                          valid_s [QUOT_BITS];
	logic [2:0][31:0]              rem_s   [QUOT_BITS];
	logic [2:0][QUOT_BITS-1:0]     num_s   [QUOT_BITS];
	logic [2:0][QUOT_BITS-1:0]     quot_s  [QUOT_BITS];
	logic [31:0]                   root_s  [QUOT_BITS];
	logic [SIDE_W-1:0]             side_s  [QUOT_BITS];

	for (genvar j = 0; j < QUOT_BITS; j++) begin : g_stage
		logic                      pv;
		logic [2:0][31:0]          prem;
		logic [2:0][QUOT_BITS-1:0] pnum;
		logic [2:0][QUOT_BITS-1:0] pquot;
		logic [31:0]               proot;
		logic [SIDE_W-1:0]         pside;
		logic [2:0][31:0]          rem_n;
		logic [2:0][QUOT_BITS-1:0] quot_n;
		logic [32:0]               cur;

		if (j == 0) begin : g_first
			assign pv    = valid_s0;
			assign prem  = {{1'b0, num_s0[2][61:31]}, {1'b0, num_s0[1][61:31]},
			                {1'b0, num_s0[0][61:31]}};
			assign pnum  = {num_s0[2][30:0], num_s0[1][30:0], num_s0[0][30:0]};
			assign pquot = '0;
			assign proot = root_s0;
			assign pside = side_s0;
		end else begin : g_next
			assign pv    = valid_s[j-1];
			assign prem  = rem_s[j-1];
			assign pnum  = num_s[j-1];
			assign pquot = quot_s[j-1];
			assign proot = root_s[j-1];
			assign pside = side_s[j-1];
		end

		// Restoring step on each lane
		always_comb begin
			cur = '0;
			for (int k = 0; k < 3; k++) begin
				cur = {prem[k], pnum[k][QUOT_BITS-1]};
				if (cur >= {1'b0, proot}) begin
					rem_n[k]  = 32'(cur - {1'b0, proot});
					quot_n[k] = {pquot[k][QUOT_BITS-2:0], 1'b1};
				end else begin
					rem_n[k]  = cur[31:0];
					quot_n[k] = {pquot[k][QUOT_BITS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (en) begin
				valid_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= rem_n;
				quot_s[j] <= quot_n;
				for (int k = 0; k < 3; k++) begin
					num_s[j][k] <= {pnum[k][QUOT_BITS-2:0], 1'b0};
				end
				root_s[j] <= proot;
				side_s[j] <= pside;
			end
		end
	end

	assign valid_o = valid_s[QUOT_BITS-1];
	assign quot_o  = quot_s[QUOT_BITS-1];
	assign side_o  = side_s[QUOT_BITS-1];

endmodule

/* rtl/aavr_cordic.sv */
// Pipelined rotation-mode CORDIC giving cosine and sine in Q1.30.
`timescale 1ns / 1ps

module aavr_cordic
	import aavr_pkg::*;
#(
	parameter int STEPS  = 24,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_i,
	input  logic [31:0]       angle_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              valid_o,
	output logic [31:0]       cos_o,
	output logic [31:0]       sin_o,
	output logic [SIDE_W-1:0] side_o
);

	// Fold angles beyond a quarter turn by half a turn
	logic signed [33:0] z_c;
	logic               flip_c;
	always_comb begin
		z_c    = 34'($signed(angle_i));
		flip_c = 1'b0;
		if (z_c > ONE_Q30) begin
			z_c    = z_c - HALF_TURN;
			flip_c = 1'b1;
		end else if (z_c < -ONE_Q30) begin
			z_c    = z_c + HALF_TURN;
			flip_c = 1'b1;
		end
	end

	logic               valid_s0;
	logic signed [33:0] z_s0;
	logic               flip_s0;
	logic [SIDE_W-1:0]  side_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en) begin
			valid_s0 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s0    <= z_c;
			flip_s0 <= flip_c;
			side_s0 <= side_i;
		end
	end

	logic               valid_s [STEPS];
	logic signed [33:0] x_s     [STEPS];
	logic signed [33:0] y_s     [STEPS];
	logic signed [33:0] z_s     [STEPS];
	logic               flip_s  [STEPS];
	logic [SIDE_W-1:0]  side_s  [STEPS];

	for (genvar j = 0; j < STEPS; j++) begin : g_iter
		logic               pv, pflip;
		logic signed [33:0] px, py, pz;
		logic [SIDE_W-1:0]  pside;
		logic signed [33:0] xn, yn, zn, at;

		if (j == 0) begin : g_first
			assign pv    = valid_s0;
			assign px    = GAIN_Q30;
			assign py    = '0;
			assign pz    = z_s0;
			assign pflip = flip_s0;
			assign pside = side_s0;
		end else begin : g_next
			assign pv    = valid_s[j-1];
			assign px    = x_s[j-1];
			assign py    = y_s[j-1];
			assign pz    = z_s[j-1];
			assign pflip = flip_s[j-1];
			assign pside = side_s[j-1];
		end

		// One micro-rotation
		always_comb begin
			at = $signed({2'b00, atan_entry(j)});
			if (!pz[33]) begin
				xn = px - (py >>> j);
				yn = py + (px >>> j);
				zn = pz - at;
			end else begin
				xn = px + (py >>> j);
				yn = py - (px >>> j);
				zn = pz + at;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (en) begin
				valid_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[j]    <= xn;
				y_s[j]    <= yn;
				z_s[j]    <= zn;
				flip_s[j] <= pflip;
				side_s[j] <= pside;
			end
		end
	end

	// Undo the fold and clamp to plus or minus one
	logic signed [33:0] xf, yf;
	always_comb begin
		xf = flip_s[STEPS-1] ? -x_s[STEPS-1] : x_s[STEPS-1];
		yf = flip_s[STEPS-1] ? -y_s[STEPS-1] : y_s[STEPS-1];
		if (xf > ONE_Q30)  xf = ONE_Q30;
		if (xf < -ONE_Q30) xf = -ONE_Q30;
		if (yf > ONE_Q30)  yf = ONE_Q30;
		if (yf < -ONE_Q30) yf = -ONE_Q30;
	end

	logic              valid_sf;
	logic [31:0]       cos_sf, sin_sf;
	logic [SIDE_W-1:0] side_sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sf <= 1'b0;
		end else if (en) begin
			valid_sf <= valid_s[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_sf  <= xf[31:0];
			sin_sf  <= yf[31:0];
			side_sf <= side_s[STEPS-1];
		end
	end

	assign valid_o = valid_sf;
	assign cos_o   = cos_sf;
	assign sin_o   = sin_sf;
	assign side_o  = side_sf;

endmodule

/* rtl/axis_angle_vector_rotation_unit.sv */
// Top level of the axis-angle (Rodrigues) vector rotation unit.
`timescale 1ns / 1ps

// Rotates a 3-D Q15.16 vector about an arbitrary axis by a binary angle.
// Input channel: in_valid/in_ready carry one word of vec_x/y/z, axis_x/y/z
// and angle. Output channel: out_valid/out_ready carry out_x/y/z with the
// zero_axis and saturated flags. Each input word gives exactly one result.
// The axis need not be unit length; an all-zero axis passes the vector
// through unchanged with zero_axis set.
// Throughput: one word per cycle while the pipe is not held. Stages in order:
// axis scaling and sum of squares, square root (one bit per stage),
// normalizing divide (one bit per stage), sine/cosine (CORDIC_STEPS
// micro-rotations) and rotation products with saturation.
// The whole pipe advances together; when the receiver holds out_ready low
// with a result waiting, every stage holds and in_ready drops, so nothing
// is lost or repeated. Reset empties the pipe; no state survives a word.
module axis_angle_vector_rotation_unit
	import aavr_pkg::*;
#(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] vec_x,
	input  logic [31:0] vec_y,
	input  logic [31:0] vec_z,
	input  logic [31:0] axis_x,
	input  logic [31:0] axis_y,
	input  logic [31:0] axis_z,
	input  logic [31:0] angle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic        zero_axis,
	output logic        saturated
);

	localparam int IN_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int STEPS   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam logic signed [43:0] OUT_HI = (44'sd1 <<< (IN_BITS - 1)) - 44'sd1;
	localparam logic signed [43:0] OUT_LO = -(44'sd1 <<< (IN_BITS - 1));

	function automatic logic signed [71:0] rnd30(input logic signed [71:0] p);
		return (p + 72'sd536870912) >>> 30;
	endfunction

	logic en;
	logic vld_s6;

	// Global advance: hold everything while a result waits
	assign en       = !vld_s6 || out_ready;
	assign in_ready = en;

	// Axis scaling and sum of squares
	logic       nm_valid;
	norm_side_t nm_side;
	logic [63:0] nm_m2;

	aavr_norm #(
		.IN_BITS(IN_BITS)
	) u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (in_valid && in_ready),
		.vec_x   (vec_x),
		.vec_y   (vec_y),
		.vec_z   (vec_z),
		.axis_x  (axis_x),
		.axis_y  (axis_y),
		.axis_z  (axis_z),
		.angle   (angle),
		.valid_o (nm_valid),
		.side_o  (nm_side),
		.m2_o    (nm_m2)
	);

	// Axis length
	logic        sq_valid;
	logic [31:0] sq_root;
	norm_side_t  sq_side;

	aavr_sqrt #(
		.SIDE_W($bits(norm_side_t))
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (nm_valid),
		.rad_i   (nm_m2),
		.side_i  (nm_side),
		.valid_o (sq_valid),
		.root_o  (sq_root),
		.side_o  (sq_side)
	);

	// Unit axis magnitudes
	logic                      dv_valid;
	logic [2:0][QUOT_BITS-1:0] dv_quot;
	item_t                     dv_item;

	aavr_div #(
		.SIDE_W($bits(item_t))
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (sq_valid),
		.mag_i   (sq_side.mag),
		.root_i  (sq_root),
		.side_i  (sq_side.item),
		.valid_o (dv_valid),
		.quot_o  (dv_quot),
		.side_o  (dv_item)
	);

	// Reapply the axis signs
	rot_side_t rt_side_c;
	always_comb begin
		rt_side_c.item = dv_item;
		for (int k = 0; k < 3; k++) begin
			rt_side_c.u[k] = dv_item.neg[k] ? (32'd0 - {1'b0, dv_quot[k]})
			                                : {1'b0, dv_quot[k]};
		end
	end

	// Cosine and sine
	logic        cs_valid;
	logic [31:0] cs_cos, cs_sin;
	rot_side_t   cs_side;

	aavr_cordic #(
		.STEPS  (STEPS),
		.SIDE_W ($bits(rot_side_t))
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_i (dv_valid),
		.angle_i (dv_item.angle),
		.side_i  (rt_side_c),
		.valid_o (cs_valid),
		.cos_o   (cs_cos),
		.sin_o   (cs_sin),
		.side_o  (cs_side)
	);

	// Rotation arithmetic, six stages
	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	item_t               item_s1, item_s2, item_s3, item_s4, item_s5;
	logic [2:0][31:0]    u_s1, u_s2, u_s3, u_s4;
	logic signed [31:0]  c_s1, c_s2, s_s1, s_s2;
	logic signed [32:0]  omc_s1, omc_s2;
	logic signed [63:0]  pd_s1 [3];
	logic signed [63:0]  pc_s1 [6];
	logic signed [35:0]  d_s2;
	logic signed [35:0]  w_s2 [3];
	logic signed [69:0]  pe_s3;
	logic signed [63:0]  pvc_s3 [3];
	logic signed [67:0]  pws_s3 [3];
	logic signed [39:0]  e_s4;
	logic signed [33:0]  a_s4 [3];
	logic signed [37:0]  b_s4 [3];
	logic signed [71:0]  pue_s5 [3];
	logic signed [38:0]  ab_s5 [3];
	logic [31:0]         ox_s6, oy_s6, oz_s6;
	logic                zero_s6, sat_s6;

	// Dot and cross product sums, rounded
	logic signed [65:0] dsum;
	logic signed [65:0] wsum [3];
	always_comb begin
		dsum    = 66'(pd_s1[0]) + 66'(pd_s1[1]) + 66'(pd_s1[2]);
		wsum[0] = 66'(pc_s1[0]) - 66'(pc_s1[1]);
		wsum[1] = 66'(pc_s1[2]) - 66'(pc_s1[3]);
		wsum[2] = 66'(pc_s1[4]) - 66'(pc_s1[5]);
	end

	// Final sum and saturation
	logic signed [43:0] r3 [3];
	logic [2:0][31:0]   res_c;
	logic               sat_c;
	always_comb begin
		sat_c = 1'b0;
		for (int k = 0; k < 3; k++) begin
			r3[k] = 44'(ab_s5[k]) + 44'(rnd30(pue_s5[k]));
			if (r3[k] > OUT_HI) begin
				r3[k] = OUT_HI;
				sat_c = 1'b1;
			end else if (r3[k] < OUT_LO) begin
				r3[k] = OUT_LO;
				sat_c = 1'b1;
			end
			res_c[k] = item_s5.zero ? item_s5.v[k] : r3[k][31:0];
		end
		if (item_s5.zero) sat_c = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cs_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: u.v and u x v partial products, one minus cosine
			item_s1  <= cs_side.item;
			u_s1     <= cs_side.u;
			c_s1     <= $signed(cs_cos);
			s_s1     <= $signed(cs_sin);
			omc_s1   <= 33'(ONE_Q30) - 33'($signed(cs_cos));
			for (int k = 0; k < 3; k++) begin
				pd_s1[k] <= $signed(cs_side.u[k]) * $signed(cs_side.item.v[k]);
			end
			pc_s1[0] <= $signed(cs_side.u[1]) * $signed(cs_side.item.v[2]);
			pc_s1[1] <= $signed(cs_side.u[2]) * $signed(cs_side.item.v[1]);
			pc_s1[2] <= $signed(cs_side.u[2]) * $signed(cs_side.item.v[0]);
			pc_s1[3] <= $signed(cs_side.u[0]) * $signed(cs_side.item.v[2]);
			pc_s1[4] <= $signed(cs_side.u[0]) * $signed(cs_side.item.v[1]);
			pc_s1[5] <= $signed(cs_side.u[1]) * $signed(cs_side.item.v[0]);

			// s2: rounded dot and cross products
			item_s2 <= item_s1;
			u_s2    <= u_s1;
			c_s2    <= c_s1;
			s_s2    <= s_s1;
			omc_s2  <= omc_s1;
			d_s2    <= 36'(rnd30(72'(dsum)));
			for (int k = 0; k < 3; k++) begin
				w_s2[k] <= 36'(rnd30(72'(wsum[k])));
			end

			// s3: d*(1-c), v*c, w*s
			item_s3 <= item_s2;
			u_s3    <= u_s2;
			pe_s3   <= 70'(d_s2) * 70'(omc_s2);
			for (int k = 0; k < 3; k++) begin
				pvc_s3[k] <= $signed(item_s2.v[k]) * c_s2;
				pws_s3[k] <= 68'(w_s2[k]) * 68'(s_s2);
			end

			// s4: round them
			item_s4 <= item_s3;
			u_s4    <= u_s3;
			e_s4    <= 40'(rnd30(72'(pe_s3)));
			for (int k = 0; k < 3; k++) begin
				a_s4[k] <= 34'(rnd30(72'(pvc_s3[k])));
				b_s4[k] <= 38'(rnd30(72'(pws_s3[k])));
			end

			// s5: u*e and the first two terms
			item_s5 <= item_s4;
			for (int k = 0; k < 3; k++) begin
				pue_s5[k] <= 72'($signed(u_s4[k])) * 72'(e_s4);
				ab_s5[k]  <= 39'(a_s4[k]) + 39'(b_s4[k]);
			end

			// s6: output register
			ox_s6   <= res_c[0];
			oy_s6   <= res_c[1];
			oz_s6   <= res_c[2];
			zero_s6 <= item_s5.zero;
			sat_s6  <= sat_c;
		end
	end

	assign out_valid = vld_s6;
	assign out_x     = ox_s6;
	assign out_y     = oy_s6;
	assign out_z     = oz_s6;
	assign zero_axis = zero_s6;
	assign saturated = sat_s6;

	// A passed-through vector is never flagged as clamped
	a_zero_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_axis |-> !saturated)
		else $error("zero axis word flagged as saturated");

	// Cosine and sine leave the CORDIC inside plus or minus one
	a_cs_range: assert property (@(posedge clk) disable iff (!arst_n)
		cs_valid |-> ($signed(cs_cos) <= 32'sd1073741824) &&
		             ($signed(cs_cos) >= -32'sd1073741824) &&
		             ($signed(cs_sin) <= 32'sd1073741824) &&
		             ($signed(cs_sin) >= -32'sd1073741824))
		else $error("cosine or sine out of range");

	// Normalized axis components never exceed one
	a_unit_axis: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && !dv_item.zero |-> (dv_quot[0] <= 31'd1073741824) &&
		                              (dv_quot[1] <= 31'd1073741824) &&
		                              (dv_quot[2] <= 31'd1073741824))
		else $error("normalized axis component above one");

endmodule
